[src/srd_pkg.sv]
// ----------------------------------------------------------------------------
// Servo reply deframer package
// Shared types and codes for the servo reply deframer.
// ----------------------------------------------------------------------------
package srd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned INDEX_W  = 16;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned LENGTH_W = 16;
    localparam int unsigned BCOUNT_W = 17;
    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_HDR2 = 4'd1,
        PH_ID   = 4'd2,
        PH_FLAG = 4'd3,
        PH_ADDR = 4'd4,
        PH_LEN  = 4'd5,
        PH_CNT  = 4'd6,
        PH_DATA = 4'd7,
        PH_CSUM = 4'd8,
        PH_DROP = 4'd9
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_ID    = 3'd1,
        ST_BAD_ADDR  = 3'd2,
        ST_BAD_LEN   = 3'd3,
        ST_BAD_COUNT = 3'd4,
        ST_BAD_CSUM  = 3'd5
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EXP_ID      = 2'd0,
        REG_EXP_ADDRESS = 2'd1,
        REG_EXP_LENGTH  = 2'd2,
        REG_EXP_COUNT   = 2'd3
    } cfg_reg_t;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

endpackage

[src/srd_rx_if.sv]
// ----------------------------------------------------------------------------
// Servo reply deframer byte channel
// Carries one received byte per item with its frame start mark.
// ----------------------------------------------------------------------------
interface srd_rx_if
    import srd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    logic              frame_begin;

    modport source (output valid, output rx_byte, output frame_begin, input ready);
    modport sink   (input valid, input rx_byte, input frame_begin, output ready);

endinterface

[src/srd_result_if.sv]
// ----------------------------------------------------------------------------
// Servo reply deframer result channel
// Carries one payload byte or one end-of-frame status per item.
// ----------------------------------------------------------------------------
interface srd_result_if
    import srd_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                result_kind;
    logic [BYTE_W-1:0]   payload_byte;
    logic [INDEX_W-1:0]  payload_index;
    logic [STATUS_W-1:0] frame_status;
    logic [BYTE_W-1:0]   received_flag;
    logic [LENGTH_W-1:0] frame_length;
    logic                frame_last;

    modport source (
        output valid, output result_kind, output payload_byte, output payload_index,
        output frame_status, output received_flag, output frame_length,
        output frame_last, input ready
    );
    modport sink (
        input valid, input result_kind, input payload_byte, input payload_index,
        input frame_status, input received_flag, input frame_length,
        input frame_last, output ready
    );

endinterface

[src/servo_reply_deframer.sv]
// A result is captured in the result register and appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the single result register is refilled in the
// cycle it is taken, so the byte input stalls only while a result waits unread.
// Reset clears the parse phase, counters, checksum, captured flag, the four
// expected-value registers and the result valid flag.
// ----------------------------------------------------------------------------
// Servo reply deframer
// Parses a servo reply frame one byte per item, checks its fields and checksum,
// and emits each payload byte followed by one end-of-frame status.
// ----------------------------------------------------------------------------
module servo_reply_deframer
    import srd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    srd_rx_if.sink               rx,
    srd_result_if.source         result
);

    logic [BYTE_W-1:0]   exp_id_reg;
    logic [BYTE_W-1:0]   exp_addr_reg;
    logic [BYTE_W-1:0]   exp_len_reg;
    logic [BYTE_W-1:0]   exp_count_reg;

    phase_t              phase_reg, phase_next;
    logic [INDEX_W-1:0]  pcount_reg, pcount_next;
    logic [BYTE_W-1:0]   xor_reg, xor_next;
    logic [BYTE_W-1:0]   flag_reg, flag_next;
    logic [BCOUNT_W-1:0] bcount_reg, bcount_next;

    logic                res_valid_reg, res_valid_next;
    logic                res_kind_reg, res_kind_next;
    logic [BYTE_W-1:0]   res_byte_reg, res_byte_next;
    logic [INDEX_W-1:0]  res_index_reg, res_index_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [BYTE_W-1:0]   res_flag_reg, res_flag_next;
    logic [LENGTH_W-1:0] res_length_reg, res_length_next;

    logic                in_fire;
    logic                emit;
    logic                do_status;
    status_t             status;
    logic [INDEX_W-1:0]  payload_total;
    logic [BCOUNT_W-1:0] bcount_inc;

    assign rx.ready = !res_valid_reg || result.ready;
    assign in_fire  = rx.valid && rx.ready;

    assign payload_total = INDEX_W'(exp_len_reg) * INDEX_W'(exp_count_reg);
    assign bcount_inc    = bcount_reg + BCOUNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_id_reg    <= '0;
            exp_addr_reg  <= '0;
            exp_len_reg   <= '0;
            exp_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_EXP_ID:      exp_id_reg    <= cfg_data;
                REG_EXP_ADDRESS: exp_addr_reg  <= cfg_data;
                REG_EXP_LENGTH:  exp_len_reg   <= cfg_data;
                REG_EXP_COUNT:   exp_count_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        pcount_next     = pcount_reg;
        xor_next        = xor_reg;
        flag_next       = flag_reg;
        bcount_next     = bcount_reg;
        emit            = 1'b0;
        do_status       = 1'b0;
        status          = ST_OK;
        res_kind_next   = KIND_PAYLOAD;
        res_byte_next   = '0;
        res_index_next  = '0;
        res_status_next = '0;
        res_flag_next   = flag_reg;
        res_length_next = '0;

        if (rx.frame_begin)
        begin
            phase_next  = PH_HDR2;
            pcount_next = '0;
            xor_next    = '0;
            flag_next   = '0;
            bcount_next = BCOUNT_W'(1);
        end
        else
        begin
            unique case (phase_reg)
                PH_HDR2:
                begin
                    bcount_next = bcount_inc;
                    phase_next  = PH_ID;
                end
                PH_ID:
                begin
                    bcount_next = bcount_inc;
                    xor_next    = xor_reg ^ rx.rx_byte;
                    if (rx.rx_byte != exp_id_reg)
                    begin
                        do_status = 1'b1;
                        status    = ST_BAD_ID;
                    end
                    else
                    begin
                        phase_next = PH_FLAG;
                    end
                end
                PH_FLAG:
                begin
                    bcount_next = bcount_inc;
                    xor_next    = xor_reg ^ rx.rx_byte;
                    flag_next   = rx.rx_byte;
                    phase_next  = PH_ADDR;
                end
                PH_ADDR:
                begin
                    bcount_next = bcount_inc;
                    xor_next    = xor_reg ^ rx.rx_byte;
                    if (rx.rx_byte != exp_addr_reg)
                    begin
                        do_status = 1'b1;
                        status    = ST_BAD_ADDR;
                    end
                    else
                    begin
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    bcount_next = bcount_inc;
                    xor_next    = xor_reg ^ rx.rx_byte;
                    if (rx.rx_byte != exp_len_reg)
                    begin
                        do_status = 1'b1;
                        status    = ST_BAD_LEN;
                    end
                    else
                    begin
                        phase_next = PH_CNT;
                    end
                end
                PH_CNT:
                begin
                    bcount_next = bcount_inc;
                    xor_next    = xor_reg ^ rx.rx_byte;
                    if (rx.rx_byte != exp_count_reg)
                    begin
                        do_status = 1'b1;
                        status    = ST_BAD_COUNT;
                    end
                    else
                    begin
                        pcount_next = '0;
                        phase_next  = (payload_total == '0) ? PH_CSUM : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    bcount_next    = bcount_inc;
                    xor_next       = xor_reg ^ rx.rx_byte;
                    emit           = 1'b1;
                    res_kind_next  = KIND_PAYLOAD;
                    res_byte_next  = rx.rx_byte;
                    res_index_next = pcount_reg;
                    if (({1'b0, pcount_reg} + 17'd1) >= {1'b0, payload_total})
                    begin
                        phase_next = PH_CSUM;
                    end
                    pcount_next = pcount_reg + INDEX_W'(1);
                end
                PH_CSUM:
                begin
                    bcount_next = bcount_inc;
                    do_status   = 1'b1;
                    status      = (rx.rx_byte == xor_reg) ? ST_OK : ST_BAD_CSUM;
                end
                PH_DROP:
                begin
                    phase_next = PH_DROP;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase

            if (do_status)
            begin
                emit            = 1'b1;
                res_kind_next   = KIND_STATUS;
                res_status_next = status;
                res_length_next = (status == ST_OK) ? bcount_next[LENGTH_W-1:0] : '0;
                phase_next      = (status == ST_OK) ? PH_IDLE : PH_DROP;
            end
        end

        if (in_fire)
        begin
            res_valid_next = emit;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            pcount_reg    <= '0;
            xor_reg       <= '0;
            flag_reg      <= '0;
            bcount_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (in_fire)
            begin
                phase_reg  <= phase_next;
                pcount_reg <= pcount_next;
                xor_reg    <= xor_next;
                flag_reg   <= flag_next;
                bcount_reg <= bcount_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && emit)
        begin
            res_kind_reg   <= res_kind_next;
            res_byte_reg   <= res_byte_next;
            res_index_reg  <= res_index_next;
            res_status_reg <= res_status_next;
            res_flag_reg   <= res_flag_next;
            res_length_reg <= res_length_next;
        end
    end

    assign result.valid         = res_valid_reg;
    assign result.result_kind   = res_kind_reg;
    assign result.payload_byte  = res_byte_reg;
    assign result.payload_index = res_index_reg;
    assign result.frame_status  = res_status_reg;
    assign result.received_flag = res_flag_reg;
    assign result.frame_length  = res_length_reg;
    assign result.frame_last    = res_kind_reg;

    a_begin_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && rx.frame_begin |=> phase_reg == PH_HDR2 && bcount_reg == BCOUNT_W'(1))
        else $error("frame start did not restart parsing");

    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_kind_reg == KIND_PAYLOAD |->
            res_status_reg == ST_OK && res_length_reg == '0)
        else $error("payload item carries status or length");

    a_error_no_length: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_kind_reg == KIND_STATUS && res_status_reg != ST_OK |->
            res_length_reg == '0)
        else $error("error status carries a frame length");

    a_error_drops: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && emit && res_kind_next == KIND_STATUS && status != ST_OK |=>
            phase_reg == PH_DROP)
        else $error("error status did not enter the drop phase");

    a_result_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid_reg && !in_fire |=> !res_valid_reg)
        else $error("result appeared without an accepted item");

endmodule

[dv/tb_servo_reply_deframer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Servo reply deframer testbench
// Drives framed servo replies byte by byte through the input channel and
// checks every payload and status item against a cycle-free predictor of the
// parser. The sender idles in random bursts and the receiver stalls in random
// patterns, including one long hold-off that fills the block and stalls its
// input. Directed frames cover idle and dropped bytes, abandoned frames, every
// status code and the register extremes; random frames cover the rest.
// ----------------------------------------------------------------------------
module tb_servo_reply_deframer;
    import srd_pkg::*;

    localparam int unsigned ITEM_TARGET = 1850;
    localparam int unsigned HOLD_CYCLES = 300;

    typedef enum int unsigned {
        FR_GOOD,
        FR_BAD_ID,
        FR_BAD_ADDR,
        FR_BAD_LEN,
        FR_BAD_COUNT,
        FR_BAD_CSUM,
        FR_CUT
    } frame_fault_t;

    typedef enum int unsigned {
        RDY_FREE,
        RDY_HALF,
        RDY_SPARSE,
        RDY_MOSTLY
    } ready_mode_t;

    typedef struct packed {
        logic                kind;
        logic [BYTE_W-1:0]   data;
        logic [INDEX_W-1:0]  index;
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   flag;
        logic [LENGTH_W-1:0] length;
        logic                last;
    } deframer_result_t;

    typedef logic [BYTE_W-1:0] byte_q_t [$];

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_data;

    srd_rx_if     rx_ch ();
    srd_result_if res_ch ();

    servo_reply_deframer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx        (rx_ch),
        .result    (res_ch)
    );

    logic [BYTE_W-1:0]   lim_id;
    logic [BYTE_W-1:0]   lim_addr;
    logic [BYTE_W-1:0]   lim_len;
    logic [BYTE_W-1:0]   lim_cnt;

    phase_t              prs_phase;
    logic [INDEX_W-1:0]  prs_index;
    logic [BYTE_W-1:0]   prs_xor;
    logic [BYTE_W-1:0]   prs_flag;
    logic [BCOUNT_W-1:0] prs_count;

    deframer_result_t    pending_results [$];
    int unsigned         items_sent = 0;
    int unsigned         burst_left = 0;
    int unsigned         hold_requests = 0;
    int unsigned         mismatches = 0;

    always #6 clk = ~clk;

    initial
    begin
        #4_800_000;
        $display("tb_servo_reply_deframer: done, errors");
        $finish;
    end

    task automatic deframe_byte(input logic [BYTE_W-1:0] b, input logic fb);
        deframer_result_t r;
        logic             done;
        status_t          st;
        int unsigned      total;
        r     = '0;
        done  = 1'b0;
        st    = ST_OK;
        total = lim_len * lim_cnt;
        if (fb)
        begin
            prs_phase = PH_HDR2;
            prs_index = '0;
            prs_xor   = '0;
            prs_flag  = '0;
            prs_count = BCOUNT_W'(1);
        end
        else
        begin
            case (prs_phase)
                PH_HDR2:
                begin
                    prs_count = prs_count + 1'b1;
                    prs_phase = PH_ID;
                end
                PH_ID:
                begin
                    prs_count = prs_count + 1'b1;
                    prs_xor   = prs_xor ^ b;
                    if (b != lim_id)
                    begin
                        done = 1'b1;
                        st   = ST_BAD_ID;
                    end
                    else
                        prs_phase = PH_FLAG;
                end
                PH_FLAG:
                begin
                    prs_count = prs_count + 1'b1;
                    prs_xor   = prs_xor ^ b;
                    prs_flag  = b;
                    prs_phase = PH_ADDR;
                end
                PH_ADDR:
                begin
                    prs_count = prs_count + 1'b1;
                    prs_xor   = prs_xor ^ b;
                    if (b != lim_addr)
                    begin
                        done = 1'b1;
                        st   = ST_BAD_ADDR;
                    end
                    else
                        prs_phase = PH_LEN;
                end
                PH_LEN:
                begin
                    prs_count = prs_count + 1'b1;
                    prs_xor   = prs_xor ^ b;
                    if (b != lim_len)
                    begin
                        done = 1'b1;
                        st   = ST_BAD_LEN;
                    end
                    else
                        prs_phase = PH_CNT;
                end
                PH_CNT:
                begin
                    prs_count = prs_count + 1'b1;
                    prs_xor   = prs_xor ^ b;
                    if (b != lim_cnt)
                    begin
                        done = 1'b1;
                        st   = ST_BAD_COUNT;
                    end
                    else
                    begin
                        prs_index = '0;
                        prs_phase = (total == 0) ? PH_CSUM : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    prs_count = prs_count + 1'b1;
                    prs_xor   = prs_xor ^ b;
                    r.kind    = KIND_PAYLOAD;
                    r.data    = b;
                    r.index   = prs_index;
                    r.flag    = prs_flag;
                    pending_results.push_back(r);
                    if (32'(prs_index) + 1 >= total)
                        prs_phase = PH_CSUM;
                    prs_index = prs_index + 1'b1;
                end
                PH_CSUM:
                begin
                    prs_count = prs_count + 1'b1;
                    done      = 1'b1;
                    st        = (b == prs_xor) ? ST_OK : ST_BAD_CSUM;
                end
                PH_DROP:
                begin
                end
                default:
                    prs_phase = PH_IDLE;
            endcase
        end
        if (done)
        begin
            r.kind    = KIND_STATUS;
            r.status  = st;
            r.flag    = prs_flag;
            r.length  = (st == ST_OK) ? prs_count[LENGTH_W-1:0] : '0;
            r.last    = 1'b1;
            pending_results.push_back(r);
            prs_phase = (st == ST_OK) ? PH_IDLE : PH_DROP;
        end
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fb);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap)
            begin
                rx_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
        burst_left--;
        rx_ch.valid       <= 1'b1;
        rx_ch.rx_byte     <= b;
        rx_ch.frame_begin <= fb;
        @(posedge clk);
        while (rx_ch.ready !== 1'b1)
            @(posedge clk);
        deframe_byte(b, fb);
        items_sent++;
    endtask

    task automatic send_seq(input byte_q_t q);
        foreach (q[i])
            send_byte(q[i], i == 0);
    endtask

    task automatic send_with_csum(input byte_q_t q, input logic corrupt);
        logic [BYTE_W-1:0] x;
        x = '0;
        for (int i = 2; i < q.size(); i++)
            x = x ^ q[i];
        if (corrupt)
            x = x ^ 8'($urandom_range(1, 255));
        q.push_back(x);
        send_seq(q);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [BYTE_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        case (idx)
            REG_EXP_ID:      lim_id   = v;
            REG_EXP_ADDRESS: lim_addr = v;
            REG_EXP_LENGTH:  lim_len  = v;
            default:         lim_cnt  = v;
        endcase
    endtask

    task automatic set_limits(input logic [BYTE_W-1:0] id, input logic [BYTE_W-1:0] addr,
                              input logic [BYTE_W-1:0] len, input logic [BYTE_W-1:0] cnt);
        write_reg(REG_EXP_ID, id);
        write_reg(REG_EXP_ADDRESS, addr);
        write_reg(REG_EXP_LENGTH, len);
        write_reg(REG_EXP_COUNT, cnt);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        rx_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [BYTE_W-1:0] any_byte();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] spoil(input logic hit);
        return hit ? 8'($urandom_range(1, 255)) : 8'h00;
    endfunction

    task automatic send_random_frame(input frame_fault_t fault);
        byte_q_t     q;
        int unsigned n_pay;
        int unsigned cut;
        n_pay = lim_len * lim_cnt;
        q.push_back(8'($urandom));
        q.push_back(8'($urandom));
        q.push_back(lim_id ^ spoil(fault == FR_BAD_ID));
        q.push_back(any_byte());
        q.push_back(lim_addr ^ spoil(fault == FR_BAD_ADDR));
        q.push_back(lim_len ^ spoil(fault == FR_BAD_LEN));
        q.push_back(lim_cnt ^ spoil(fault == FR_BAD_COUNT));
        repeat (n_pay) q.push_back(8'($urandom));
        case (fault)
            FR_BAD_ID:    cut = 3;
            FR_BAD_ADDR:  cut = 5;
            FR_BAD_LEN:   cut = 6;
            FR_BAD_COUNT: cut = 7;
            FR_CUT:       cut = $urandom_range(1, q.size());
            default:      cut = 0;
        endcase
        if (cut != 0)
        begin
            while (q.size() > cut)
                void'(q.pop_back());
            repeat ($urandom_range(0, 3)) q.push_back(8'($urandom));
            send_seq(q);
        end
        else
            send_with_csum(q, fault == FR_BAD_CSUM);
    endtask

    task automatic test_directed();
        byte_q_t q;
        set_limits(8'hFF, 8'h00, 8'd1, 8'd1);
        send_byte(8'h00, 1'b0);
        q = '{8'hFF, 8'hFF, 8'hFF, 8'h80};
        send_seq(q);
        q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'h01, 8'h00};
        send_with_csum(q, 1'b0);
        q = '{8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h01, 8'h01, 8'hFF};
        send_with_csum(q, 1'b1);
        send_byte(8'hFF, 1'b0);
        q = '{8'h00, 8'h00, 8'h7F};
        send_seq(q);
        wait_idle();
    endtask

    task automatic test_field_mismatch();
        byte_q_t q;
        set_limits(8'h5A, 8'hA5, 8'd2, 8'd3);
        q = '{8'h00, 8'hFF, 8'h5A, 8'h11, 8'hA4};
        send_seq(q);
        q = '{8'h00, 8'hFF, 8'h5A, 8'h11, 8'hA5, 8'h03};
        send_seq(q);
        q = '{8'h00, 8'hFF, 8'h5A, 8'h11, 8'hA5, 8'h02, 8'h04};
        send_seq(q);
        send_random_frame(FR_GOOD);
        wait_idle();
    endtask

    task automatic test_config_extremes();
        set_limits(8'h00, 8'hFF, 8'd255, 8'd1);
        send_random_frame(FR_GOOD);
        wait_idle();
        set_limits(8'hFF, 8'hFF, 8'd0, 8'd255);
        send_random_frame(FR_GOOD);
        send_random_frame(FR_BAD_CSUM);
        wait_idle();
        set_limits(8'h00, 8'h00, 8'd255, 8'd0);
        send_random_frame(FR_GOOD);
        wait_idle();
        set_limits(8'h80, 8'h7F, 8'd1, 8'd255);
        send_random_frame(FR_GOOD);
        wait_idle();
    endtask

    task automatic test_backpressure();
        set_limits(any_byte(), any_byte(), 8'd8, 8'd4);
        hold_requests++;
        repeat (3) send_random_frame(FR_GOOD);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int unsigned pick;
        frame_fault_t fault;
        while (items_sent < ITEM_TARGET)
        begin
            set_limits(any_byte(), any_byte(), 8'($urandom_range(0, 5)),
                       8'($urandom_range(0, 4)));
            repeat ($urandom_range(6, 16))
            begin
                if ($urandom_range(0, 9) == 0)
                    send_byte(8'($urandom), 1'b0);
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    fault = FR_GOOD;
                else if (pick < 67)
                    fault = FR_BAD_ID;
                else if (pick < 74)
                    fault = FR_BAD_ADDR;
                else if (pick < 80)
                    fault = FR_BAD_LEN;
                else if (pick < 86)
                    fault = FR_BAD_COUNT;
                else if (pick < 93)
                    fault = FR_BAD_CSUM;
                else
                    fault = FR_CUT;
                send_random_frame(fault);
            end
            wait_idle();
        end
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        deframer_result_t want;
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result item with none expected: kind %0d", res_ch.result_kind);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("result_kind", 16'(want.kind), 16'(res_ch.result_kind));
                check_field("payload_byte", 16'(want.data), 16'(res_ch.payload_byte));
                check_field("payload_index", want.index, res_ch.payload_index);
                check_field("frame_status", 16'(want.status), 16'(res_ch.frame_status));
                check_field("received_flag", 16'(want.flag), 16'(res_ch.received_flag));
                check_field("frame_length", want.length, res_ch.frame_length);
                check_field("frame_last", 16'(want.last), 16'(res_ch.frame_last));
            end
        end
    end

    initial
    begin
        int unsigned hold_left;
        int unsigned holds_done;
        int unsigned mode_left;
        ready_mode_t ready_mode;
        hold_left  = 0;
        holds_done = 0;
        mode_left  = 0;
        ready_mode = RDY_FREE;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (holds_done != hold_requests)
            begin
                holds_done++;
                hold_left = HOLD_CYCLES;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode_left  = $urandom_range(20, 200);
                    ready_mode = ready_mode_t'($urandom_range(0, 3));
                end
                mode_left--;
                case (ready_mode)
                    RDY_FREE:   res_ch.ready <= 1'b1;
                    RDY_HALF:   res_ch.ready <= 1'($urandom_range(0, 1));
                    RDY_SPARSE: res_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:    res_ch.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial
    begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= REG_EXP_ID;
        cfg_data          <= '0;
        rx_ch.valid       <= 1'b0;
        rx_ch.rx_byte     <= '0;
        rx_ch.frame_begin <= 1'b0;
        lim_id    = '0;
        lim_addr  = '0;
        lim_len   = '0;
        lim_cnt   = '0;
        prs_phase = PH_IDLE;
        prs_index = '0;
        prs_xor   = '0;
        prs_flag  = '0;
        prs_count = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_field_mismatch();
        test_config_extremes();
        test_backpressure();
        test_random_traffic();

        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("tb_servo_reply_deframer: done, clean");
        else
            $display("tb_servo_reply_deframer: done, errors");
        $finish;
    end

endmodule

[filelist.f]
src/srd_pkg.sv
src/srd_rx_if.sv
src/srd_result_if.sv
src/servo_reply_deframer.sv
dv/tb_servo_reply_deframer.sv
